// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port-level checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");

// checked on every rising edge outside of reset
`define ASSERT_RUN(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/fscc_pkg.sv =====
// shared types and constants of the save flash command controller
// no dependencies
package fscc_pkg;

  localparam int unsigned FLASH_BYTES_DEF = 131072;
  localparam int unsigned BANK_BYTES      = 65536;
  localparam int unsigned SECTOR_BYTES    = 4096;
  localparam int unsigned OFF_W           = $clog2(BANK_BYTES);
  localparam int unsigned SECTOR_W        = $clog2(SECTOR_BYTES);
  localparam int unsigned ADDR_W          = 25;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAKER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 1'b1;

  localparam logic [DATA_W-1:0] MAKER_RST   = 8'h62;
  localparam logic [DATA_W-1:0] DEVICE_RST  = 8'h13;
  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hff;

  localparam logic [ADDR_W-1:0] CMD_ADDR   = 25'h0005555;
  localparam logic [OFF_W-1:0]  FIRST_OFF  = 16'h5555;
  localparam logic [OFF_W-1:0]  SECOND_OFF = 16'h2aaa;

  localparam logic [DATA_W-1:0] UNLOCK_FIRST  = 8'haa;
  localparam logic [DATA_W-1:0] UNLOCK_SECOND = 8'h55;

  localparam logic [DATA_W-1:0] CMD_ERASE_ALL = 8'h10;
  localparam logic [DATA_W-1:0] CMD_ERASE     = 8'h80;
  localparam logic [DATA_W-1:0] CMD_ID_ON     = 8'h90;
  localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'ha0;
  localparam logic [DATA_W-1:0] CMD_BANK      = 8'hb0;
  localparam logic [DATA_W-1:0] CMD_ID_OFF    = 8'hf0;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ERASE   = 2'd1,
    MODE_PROGRAM = 2'd2,
    MODE_BANK    = 2'd3
  } fscc_mode_e;

  typedef struct packed {
    logic go;
    logic whole;
  } fscc_erase_t;

endpackage

// ===== hw/rtl/fscc_store.sv =====
// byte store with a registered read port and the erase sweep engine
// depends on fscc_pkg
module fscc_store import fscc_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [$clog2(FLASH_BYTES)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]              rd_data_o,
  input  logic                           wr_en_i,
  input  logic [$clog2(FLASH_BYTES)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]              wr_data_i,
  input  fscc_erase_t                    erase_i,
  input  logic [$clog2(FLASH_BYTES)-1:0] erase_base_i,
  output logic                           busy_o
);

  localparam int unsigned AW = $clog2(FLASH_BYTES);
  localparam int unsigned CW = $clog2(FLASH_BYTES + 1);

  logic [DATA_W-1:0] mem_q [FLASH_BYTES];
  logic [DATA_W-1:0] rdata_q;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  assign busy_o = (cnt_q != '0);

  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (erase_i.go) begin
      ptr_d = erase_i.whole ? '0 : erase_base_i;
      cnt_d = erase_i.whole ? CW'(FLASH_BYTES) : CW'(SECTOR_BYTES);
    end else if (busy_o) begin
      // sweep wraps at the end of the store
      ptr_d = (ptr_q == AW'(FLASH_BYTES - 1)) ? '0 : ptr_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
    end
  end

  assign mem_we    = busy_o || wr_en_i;
  assign mem_waddr = busy_o ? ptr_q : wr_addr_i;
  assign mem_wdata = busy_o ? ERASED_BYTE : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rdata_q;

endmodule

// ===== hw/rtl/flash_save_command_controller_core.sv =====
// a store read passes the store read register, then the output register; writes and id reads only the output register
// input stalls while a store read is in flight; one write or id read per cycle while the output is not stalled
// sector erase and chip erase stall input until the sweep has cleared the sector or the whole store
//   (one store byte per cycle through the single write port)
// reset clears mode, bank, id flag and unlock bytes, reloads default codes; store undefined
module flash_save_command_controller_core import fscc_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [DATA_W-1:0]    write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    read_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(FLASH_BYTES);
  localparam int unsigned IW = OFF_W + 2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_q, state_d;
  fscc_mode_e        mode_q, mode_d;
  logic              bank_q, bank_d;
  logic              id_q, id_d;
  logic [DATA_W-1:0] first_q, first_d;
  logic [DATA_W-1:0] second_q, second_d;
  logic [DATA_W-1:0] maker_q, device_q;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              pend_valid_q, pend_valid_d;
  logic [DATA_W-1:0] pend_data_q, pend_data_d;

  logic              in_fire, wr_fire, rd_fire, unlocked, out_free;
  logic              res_valid;
  logic [DATA_W-1:0] res_data, id_data;
  logic              store_busy, mem_rd_en, prog_we;
  logic [DATA_W-1:0] mem_rd_data;
  logic [AW-1:0]     acc_idx, sector_idx;
  fscc_erase_t       erase;

  function automatic logic [AW-1:0] store_index(logic bank, logic [OFF_W-1:0] off);
    logic [IW-1:0] sum;
    sum = {1'b0, bank, off};
    if (sum >= IW'(FLASH_BYTES)) begin
      sum = sum - IW'(FLASH_BYTES);
    end
    return sum[AW-1:0];
  endfunction

  assign in_stall_o = (state_q != ST_IDLE) || pend_valid_q || store_busy;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign wr_fire    = in_fire && op_i;
  assign rd_fire    = in_fire && !op_i;
  assign unlocked   = (first_q == UNLOCK_FIRST) && (second_q == UNLOCK_SECOND);

  assign acc_idx    = store_index(bank_q, address_i[OFF_W-1:0]);
  assign sector_idx = store_index(bank_q,
                                  {address_i[OFF_W-1:SECTOR_W], {SECTOR_W{1'b0}}});

  // command decode on write transfers
  always_comb begin
    mode_d   = mode_q;
    bank_d   = bank_q;
    id_d     = id_q;
    first_d  = first_q;
    second_d = second_q;
    prog_we  = 1'b0;
    erase    = '0;
    if (wr_fire) begin
      priority if (mode_q == MODE_PROGRAM) begin
        prog_we = 1'b1;
        mode_d  = MODE_IDLE;
      end else if (mode_q == MODE_BANK && address_i == '0) begin
        bank_d = write_data_i[0];
        mode_d = MODE_IDLE;
      end else if (unlocked) begin
        if (address_i == CMD_ADDR) begin
          unique case (write_data_i)
            CMD_ERASE_ALL: begin
              if (mode_q == MODE_ERASE) begin
                erase.go    = 1'b1;
                erase.whole = 1'b1;
                mode_d      = MODE_IDLE;
              end
            end
            CMD_ERASE:   mode_d = MODE_ERASE;
            CMD_ID_ON:   id_d   = 1'b1;
            CMD_PROGRAM: mode_d = MODE_PROGRAM;
            CMD_BANK:    mode_d = MODE_BANK;
            CMD_ID_OFF:  id_d   = 1'b0;
            default: ;
          endcase
        end else if (mode_q == MODE_ERASE && address_i[SECTOR_W-1:0] == '0) begin
          erase.go = 1'b1;
          mode_d   = MODE_IDLE;
        end
      end else begin
        mode_d = mode_q;
      end
      if (address_i[OFF_W-1:0] == FIRST_OFF) begin
        first_d = write_data_i;
      end else if (address_i[OFF_W-1:0] == SECOND_OFF) begin
        second_d = write_data_i;
      end
    end
  end

  assign mem_rd_en = rd_fire && !id_q;

  always_comb begin
    priority if (address_i == ADDR_W'(0)) begin
      id_data = maker_q;
    end else if (address_i == ADDR_W'(1)) begin
      id_data = device_q;
    end else begin
      id_data = '0;
    end
  end

  always_comb begin
    state_d = ST_IDLE;
    if (mem_rd_en) begin
      state_d = ST_READ;
    end
  end

  // result source: immediate for writes and id reads, store data in the cycle after the read transfer
  assign res_valid = (in_fire && (op_i || id_q)) || (state_q == ST_READ);
  always_comb begin
    priority if (state_q == ST_READ) begin
      res_data = mem_rd_data;
    end else if (op_i) begin
      res_data = '0;
    end else begin
      res_data = id_data;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    pend_valid_d = pend_valid_q;
    pend_data_d  = pend_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_valid_q) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_data_d   = pend_data_q;
        pend_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = res_data;
      end else begin
        pend_valid_d = 1'b1;
        pend_data_d  = res_data;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MODE_IDLE;
      bank_q       <= 1'b0;
      id_q         <= 1'b0;
      first_q      <= '0;
      second_q     <= '0;
      maker_q      <= MAKER_RST;
      device_q     <= DEVICE_RST;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      bank_q       <= bank_d;
      id_q         <= id_d;
      first_q      <= first_d;
      second_q     <= second_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MAKER:  maker_q  <= cfg_data_i;
          CFG_DEVICE: device_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    pend_data_q <= pend_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  fscc_store #(
    .FLASH_BYTES(FLASH_BYTES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (mem_rd_en),
    .rd_addr_i   (acc_idx),
    .rd_data_o   (mem_rd_data),
    .wr_en_i     (prog_we),
    .wr_addr_i   (acc_idx),
    .wr_data_i   (write_data_i),
    .erase_i     (erase),
    .erase_base_i(sector_idx),
    .busy_o      (store_busy)
  );

endmodule

// ===== hw/rtl/fscc_checker.sv =====
// port-level checks of the save flash command controller, bound to the top level
// depends on fscc_pkg and assert_macros.svh
`include "assert_macros.svh"

module fscc_checker import fscc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              op_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DATA_W-1:0] read_data_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);

  logic in_fire, out_held, wr_out_free;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign wr_out_free = in_fire && op_i && (!out_valid_o || !out_stall_i);

  // a stalled result holds
  `ASSERT_RUN(a_out_hold, clk_i, rst_ni, out_held |=> out_valid_o && $stable(read_data_o))

  // a write transfer shows a zero result next cycle when the output slot frees up
  `ASSERT_RUN(a_write_zero, clk_i, rst_ni, wr_out_free |=> out_valid_o && read_data_o == '0)

  // no result is shown once reset has been seen at an edge
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

  // configuration port never back-pressures
  `ASSERT_RUN(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_o)

endmodule

bind flash_save_command_controller_core fscc_checker u_fscc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

// ===== tb/sv/flash_save_command_controller_core_tb.sv =====
// testbench of the save flash command controller: byte transfers, command sequences,
// erases and code registers, checked against a behavioral copy of the flash state
// depends on fscc_pkg and flash_save_command_controller_core
module flash_save_command_controller_core_tb;
  import fscc_pkg::*;

  localparam int unsigned HI_W           = ADDR_W - OFF_W;
  localparam int          NO_ERASE       = 0;
  localparam int          SECTOR_ERASE   = 1;
  localparam int          CHIP_ERASE     = 2;
  localparam int unsigned TOTAL_ACCESSES = 1450;

  typedef struct {
    bit                wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } pending_byte_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 op_i;
  logic [ADDR_W-1:0]    address_i;
  logic [DATA_W-1:0]    write_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DATA_W-1:0]    read_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;

  // shadow of the flash state
  logic [DATA_W-1:0] flash_q [FLASH_BYTES_DEF];
  bit                written_q [FLASH_BYTES_DEF];
  bit                bank_q = 1'b0;
  fscc_mode_e        mode_q = MODE_IDLE;
  bit                id_q = 1'b0;
  logic [DATA_W-1:0] first_q = '0;
  logic [DATA_W-1:0] second_q = '0;
  logic [DATA_W-1:0] maker_q = MAKER_RST;
  logic [DATA_W-1:0] device_q = DEVICE_RST;

  pending_byte_t expected_reads[$];
  int unsigned   accesses_sent = 0;
  int unsigned   mismatch_count = 0;
  int            chip_erases_left = 2;
  int            sector_erases_left = 42;
  bit            gaps_on = 1'b1;
  bit            stalls_on = 1'b0;
  bit            hold_on = 1'b0;
  int unsigned   stall_left = 0;

  flash_save_command_controller_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned byte_slot(logic [ADDR_W-1:0] a);
    return ((bank_q ? BANK_BYTES : 0) + 32'(a[OFF_W-1:0])) % FLASH_BYTES_DEF;
  endfunction

  function automatic bit unlocked();
    return first_q == UNLOCK_FIRST && second_q == UNLOCK_SECOND;
  endfunction

  function automatic void fill_bytes(int unsigned start, int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      flash_q[(start + i) % FLASH_BYTES_DEF]   = ERASED_BYTE;
      written_q[(start + i) % FLASH_BYTES_DEF] = 1'b1;
    end
  endfunction

  function automatic int erase_kind(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    if (mode_q != MODE_ERASE || !unlocked()) return NO_ERASE;
    if (a == CMD_ADDR) return (d == CMD_ERASE_ALL) ? CHIP_ERASE : NO_ERASE;
    return (a[SECTOR_W-1:0] == '0) ? SECTOR_ERASE : NO_ERASE;
  endfunction

  function automatic void apply_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    int unsigned idx;
    idx = byte_slot(a);
    if (mode_q == MODE_PROGRAM) begin
      flash_q[idx]   = d;
      written_q[idx] = 1'b1;
      mode_q         = MODE_IDLE;
    end else if (mode_q == MODE_BANK && a == '0) begin
      bank_q = d[0];
      mode_q = MODE_IDLE;
    end else if (unlocked()) begin
      if (a == CMD_ADDR) begin
        case (d)
          CMD_ERASE_ALL: begin
            if (mode_q == MODE_ERASE) begin
              fill_bytes(0, FLASH_BYTES_DEF);
              mode_q = MODE_IDLE;
            end
          end
          CMD_ERASE:   mode_q = MODE_ERASE;
          CMD_ID_ON:   id_q = 1'b1;
          CMD_PROGRAM: mode_q = MODE_PROGRAM;
          CMD_BANK:    mode_q = MODE_BANK;
          CMD_ID_OFF:  id_q = 1'b0;
          default: ;
        endcase
      end else if (mode_q == MODE_ERASE && a[SECTOR_W-1:0] == '0) begin
        fill_bytes(byte_slot({a[ADDR_W-1:SECTOR_W], {SECTOR_W{1'b0}}}), SECTOR_BYTES);
        mode_q = MODE_IDLE;
      end
    end
    // unlock bytes are recorded on the offset within the bank
    if (a[OFF_W-1:0] == FIRST_OFF) first_q = d;
    else if (a[OFF_W-1:0] == SECOND_OFF) second_q = d;
  endfunction

  function automatic logic [DATA_W-1:0] predict_access(bit wr, logic [ADDR_W-1:0] a,
                                                       logic [DATA_W-1:0] d);
    if (wr) begin
      apply_write(a, d);
      return '0;
    end
    if (id_q) begin
      if (a == ADDR_W'(0)) return maker_q;
      if (a == ADDR_W'(1)) return device_q;
      return '0;
    end
    return flash_q[byte_slot(a)];
  endfunction

  function automatic logic [HI_W-1:0] random_hi();
    return ($urandom_range(1) == 0) ? '0 : HI_W'($urandom);
  endfunction

  function automatic void flag_mismatch(string what, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch: %s expected %02h got %02h", what, want, got);
  endfunction

  // receiver: random stall bursts, or a long hold while pressure is applied
  always @(posedge clk_i) begin
    if (hold_on) begin
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (stalls_on && $urandom_range(3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_result
    pending_byte_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reads.size() == 0) begin
        flag_mismatch("transfer with no result expected", 'x, read_data_o);
      end else begin
        head = expected_reads.pop_front();
        if (read_data_o !== head.data)
          flag_mismatch($sformatf("read_data after %s at %07h",
                                  head.wr ? "write" : "read", head.addr),
                        head.data, read_data_o);
      end
    end
  end

  task automatic send_access(bit wr, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    int kind = NO_ERASE;
    // never read a byte that was neither programmed nor erased
    if (!wr && !id_q && !written_q[byte_slot(a)]) return;
    if (wr) begin
      kind = erase_kind(a, d);
      if (kind == CHIP_ERASE && chip_erases_left <= 0) begin
        d    = '0;
        kind = NO_ERASE;
      end else if (kind == SECTOR_ERASE && sector_erases_left <= 0) begin
        a[0] = 1'b1;
        kind = NO_ERASE;
      end
    end
    if (gaps_on && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= wr;
    address_i    <= a;
    write_data_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == CHIP_ERASE) chip_erases_left--;
    else if (kind == SECTOR_ERASE) sector_erases_left--;
    expected_reads.push_back('{wr, a, predict_access(wr, a, d)});
    accesses_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_code(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAKER:  maker_q = val;
      CFG_DEVICE: device_q = val;
      default: ;
    endcase
  endtask

  task automatic unlock_seq();
    send_access(1'b1, {random_hi(), FIRST_OFF}, UNLOCK_FIRST);
    send_access(1'b1, {random_hi(), SECOND_OFF}, UNLOCK_SECOND);
  endtask

  // second unlock byte is still in place, so only the first is rewritten
  task automatic issue_command(logic [DATA_W-1:0] cmd);
    send_access(1'b1, CMD_ADDR, UNLOCK_FIRST);
    send_access(1'b1, CMD_ADDR, cmd);
  endtask

  task automatic read_at(logic [ADDR_W-1:0] a);
    send_access(1'b0, a, DATA_W'($urandom));
  endtask

  task automatic run_traffic(int unsigned until_count);
    int unsigned       pick;
    logic [ADDR_W-1:0] a;
    while (accesses_sent < until_count) begin
      pick = $urandom_range(99);
      a    = ADDR_W'($urandom);
      if (pick < 25) begin
        repeat ($urandom_range(1, 3)) read_at(ADDR_W'($urandom));
      end else if (pick < 40) begin
        unlock_seq();
        send_access(1'b1, CMD_ADDR, CMD_PROGRAM);
        send_access(1'b1, a, DATA_W'($urandom));
        read_at({random_hi(), a[OFF_W-1:0]});
      end else if (pick < 50) begin
        unlock_seq();
        send_access(1'b1, CMD_ADDR, CMD_BANK);
        // a write away from offset zero leaves the switch armed
        if ($urandom_range(2) == 0) send_access(1'b1, a | ADDR_W'(1), DATA_W'($urandom));
        send_access(1'b1, '0, DATA_W'($urandom));
        read_at(a);
      end else if (pick < 62) begin
        unlock_seq();
        send_access(1'b1, CMD_ADDR, CMD_ERASE);
        unlock_seq();
        a[SECTOR_W-1:0] = '0;
        send_access(1'b1, a, DATA_W'($urandom));
        read_at(a | ADDR_W'($urandom_range(SECTOR_BYTES - 1)));
      end else if (pick < 64) begin
        unlock_seq();
        send_access(1'b1, CMD_ADDR, CMD_ERASE);
        unlock_seq();
        send_access(1'b1, CMD_ADDR, CMD_ERASE_ALL);
        read_at(a);
      end else if (pick < 74) begin
        unlock_seq();
        send_access(1'b1, CMD_ADDR, CMD_ID_ON);
        read_at(ADDR_W'(0));
        read_at(ADDR_W'(1));
        read_at(a);
        unlock_seq();
        send_access(1'b1, CMD_ADDR, CMD_ID_OFF);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3))
          send_access(1'($urandom_range(1)), ADDR_W'($urandom), DATA_W'($urandom));
      end else begin
        // broken unlock or stray command byte
        send_access(1'b1, {random_hi(), FIRST_OFF},
                    $urandom_range(1) ? UNLOCK_FIRST : DATA_W'($urandom));
        send_access(1'b1, {random_hi(), SECOND_OFF},
                    $urandom_range(1) ? UNLOCK_SECOND : DATA_W'($urandom));
        send_access(1'b1, CMD_ADDR, DATA_W'($urandom));
      end
    end
  endtask

  task automatic test_id_codes();
    unlock_seq();
    send_access(1'b1, CMD_ADDR, CMD_ID_ON);
    read_at(ADDR_W'(0));
    read_at(ADDR_W'(1));
    read_at('1);
  endtask

  task automatic test_code_registers();
    write_code(CFG_MAKER, 8'hff);
    write_code(CFG_DEVICE, 8'h00);
    read_at(ADDR_W'(0));
    read_at(ADDR_W'(1));
    issue_command(CMD_ID_OFF);
  endtask

  task automatic test_chip_erase();
    // whole-store erase byte without erase armed does nothing
    issue_command(CMD_ERASE_ALL);
    issue_command(CMD_ERASE);
    issue_command(CMD_ERASE_ALL);
    read_at('1);
  endtask

  task automatic test_program_and_bank();
    issue_command(CMD_BANK);
    send_access(1'b1, ADDR_W'(16'h0100), 8'h5a);
    send_access(1'b1, '0, 8'h01);
    issue_command(CMD_PROGRAM);
    send_access(1'b1, ADDR_W'(20'h1f123), 8'h3c);
    read_at(ADDR_W'(16'hf123));
    issue_command(CMD_ERASE);
    send_access(1'b1, CMD_ADDR, UNLOCK_FIRST);
    send_access(1'b1, ADDR_W'(16'hf000), 8'h00);
    read_at(ADDR_W'(16'hf123));
  endtask

  task automatic test_random_traffic();
    run_traffic(600);
  endtask

  // hold the output for a long stretch while transfers keep coming
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    repeat (60) read_at(ADDR_W'($urandom));
    gaps_on = 1'b1;
  endtask

  task automatic test_code_sweep();
    write_code(CFG_MAKER, 8'h00);
    write_code(CFG_DEVICE, 8'hff);
    run_traffic(850);
    write_code(CFG_MAKER, DATA_W'($urandom));
    write_code(CFG_DEVICE, DATA_W'($urandom));
    run_traffic(1150);
    write_code(CFG_MAKER, MAKER_RST);
    write_code(CFG_DEVICE, DEVICE_RST);
  endtask

  task automatic test_quiet_traffic();
    gaps_on = 1'b0;
    stalls_on <= 1'b0;
    run_traffic(TOTAL_ACCESSES);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = 1'b0;
    address_i    = '0;
    write_data_i = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_MAKER;
    cfg_data_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stalls_on <= 1'b1;
    test_id_codes();
    test_code_registers();
    test_chip_erase();
    test_program_and_bank();
    test_random_traffic();
    test_output_backpressure();
    test_code_sweep();
    test_quiet_traffic();
    wait_drained();
    if (mismatch_count == 0 && expected_reads.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
